### hw/rtl/xorgens_4096_random_generator_defines.svh
// Assertion macros for the xorgens 4096 generator.
`ifndef XORGENS_4096_RANDOM_GENERATOR_DEFINES_SVH
`define XORGENS_4096_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define XG4K_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define XG4K_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/xg4k_pkg.sv
package xg4k_pkg;

    localparam int WORD_W = 64;
    localparam int LAG = 53;
    localparam int SEED_ROUNDS = 64;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t WEYL_STEP = 64'h61c8864680b583eb;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Seed mixer: xorshift 10/15/4/13.
    function automatic word_t seed_mix(input word_t v);
        word_t t;
        t = v ^ (v << 10);
        t = t ^ (t >> 15);
        t = t ^ (t << 4);
        t = t ^ (t >> 13);
        return t;
    endfunction

    // Table recurrence: current word through 33/26, lagged word through 27/29.
    function automatic word_t step_mix(input word_t cur, input word_t lagged);
        word_t c;
        word_t l;
        c = cur ^ (cur << 33);
        c = c ^ (c >> 26);
        l = lagged ^ (lagged << 27);
        l = l ^ (l >> 29);
        return c ^ l;
    endfunction

    function automatic word_t weyl_mix(input word_t w);
        return w ^ (w >> 27);
    endfunction

endpackage

### hw/rtl/xg4k_req_if.sv
interface xg4k_req_if;
    import xg4k_pkg::*;

    logic  valid;
    logic  ready;
    logic  operation;
    word_t seed;

    modport source (output valid, output operation, output seed, input ready);
    modport sink (input valid, input operation, input seed, output ready);
endinterface

### hw/rtl/xg4k_rsp_if.sv
interface xg4k_rsp_if;
    import xg4k_pkg::*;

    logic  valid;
    logic  ready;
    word_t random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

### hw/rtl/xorgens_4096_random_generator.sv
// xorgens 4096-bit generator, 64-bit words.
// Channel requests (valid/ready): operation 0 draws one word, 1 reseeds from seed.
// Channel results (valid/ready): one random_value per draw, nothing per reseed.
// A draw reads the current and lagged table words from a dual-read memory in
// the cycle it is accepted and writes the new word back when the result is
// loaded into the output register. Draws sustain one per cycle while results
// does not stall, limited by the single memory write port.
// A reseed holds requests.ready low through 64 mixing rounds, 64 table-fill
// writes and 256 discarded table steps. The last discard write-back overlaps
// the next draw; a second reseed waits for it to drain.
// After reset the block seeds itself with seed zero, so requests.ready rises
// only once that seeding is done.
// When results stalls, the finished word stays in the output register; one
// more draw may be accepted and is held in the read stage until the output
// register frees.
`include "xorgens_4096_random_generator_defines.svh"

module xorgens_4096_random_generator #(
    parameter int TABLE_WORDS = 64
) (
    input logic         clk,
    input logic         rst_n,
    xg4k_req_if.sink    requests,
    xg4k_rsp_if.source  results
);
    import xg4k_pkg::*;

    localparam int IDX_W = $clog2(TABLE_WORDS);
    localparam int DISCARD_STEPS = 4 * TABLE_WORDS;
    localparam int CNT_W = $clog2(DISCARD_STEPS) + 1;
    localparam logic [IDX_W-1:0] LAG_OFS = IDX_W'(TABLE_WORDS - LAG);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_MIX     = 2'd1;
    localparam logic [1:0] ST_FILL    = 2'd2;
    localparam logic [1:0] ST_DISCARD = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    word_t            mix_reg, mix_next;
    word_t            weyl_reg, weyl_next;
    logic [IDX_W-1:0] ring_reg, ring_next;

    logic             stg_valid_reg, stg_valid_next;
    logic             stg_draw_reg, stg_draw_next;
    logic [IDX_W-1:0] stg_addr_reg, stg_addr_next;
    word_t            stg_wmix_reg, stg_wmix_next;

    logic             out_valid_reg, out_valid_next;
    word_t            out_value_reg, out_value_next;

    logic             out_free;
    logic             stg_adv;
    logic             in_fire;
    logic             draw_fire;
    logic             seed_fire;
    logic             rd_go;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] lag_idx;
    word_t            mixed;
    word_t            weyl_inc;
    word_t            step_word;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    word_t            wr_data;

    assign out_free  = !out_valid_reg || results.ready;
    assign stg_adv   = stg_valid_reg && (!stg_draw_reg || out_free);

    // Reseed waits for the stage to drain; a draw may follow a step that leaves.
    assign requests.ready = (state_reg == ST_IDLE)
                          && (!stg_valid_reg || (stg_adv && requests.operation == OP_DRAW));
    assign in_fire   = requests.valid && requests.ready;
    assign draw_fire = in_fire && (requests.operation == OP_DRAW);
    assign seed_fire = in_fire && (requests.operation == OP_SEED);

    assign rd_go    = draw_fire || (state_reg == ST_DISCARD);
    assign cur_idx  = ring_reg + 1'b1;
    assign lag_idx  = cur_idx + LAG_OFS;
    assign mixed    = seed_mix(mix_reg);
    assign weyl_inc = weyl_reg + WEYL_STEP;

    // The table fill and step write-backs never overlap: a reseed needs an empty stage.
    always_comb
    begin
        if (state_reg == ST_FILL)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = mixed + weyl_inc;
        end
        else
        begin
            wr_en   = stg_adv;
            wr_addr = stg_addr_reg;
            wr_data = step_word;
        end
    end

    xg4k_table #(
        .DEPTH  (TABLE_WORDS),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk         (clk),
        .rd_en       (rd_go),
        .rd_cur_addr (cur_idx),
        .rd_lag_addr (lag_idx),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .step_word   (step_word)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mix_next   = mix_reg;
        weyl_next  = weyl_reg;
        ring_next  = ring_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (seed_fire)
                begin
                    mix_next   = (requests.seed != '0) ? requests.seed : '1;
                    count_next = '0;
                    state_next = ST_MIX;
                end
                else if (draw_fire)
                begin
                    ring_next = cur_idx;
                    weyl_next = weyl_inc;
                end
            end
            ST_MIX:
            begin
                mix_next   = mixed;
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(SEED_ROUNDS - 1))
                begin
                    weyl_next  = mixed;
                    count_next = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                mix_next   = mixed;
                weyl_next  = weyl_inc;
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(TABLE_WORDS - 1))
                begin
                    count_next = '0;
                    ring_next  = '1;
                    state_next = ST_DISCARD;
                end
            end
            ST_DISCARD:
            begin
                ring_next  = cur_idx;
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(DISCARD_STEPS - 1))
                begin
                    count_next = '0;
                    mix_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        stg_draw_next  = stg_draw_reg;
        stg_addr_next  = stg_addr_reg;
        stg_wmix_next  = stg_wmix_reg;
        if (rd_go)
        begin
            stg_valid_next = 1'b1;
            stg_draw_next  = draw_fire;
            stg_addr_next  = cur_idx;
            stg_wmix_next  = weyl_mix(weyl_inc);
        end
        else if (stg_adv)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        if (stg_adv && stg_draw_reg)
        begin
            out_valid_next = 1'b1;
            out_value_next = step_word + stg_wmix_reg;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_MIX;
            count_reg     <= '0;
            mix_reg       <= '1;
            weyl_reg      <= '0;
            ring_reg      <= '0;
            stg_valid_reg <= 1'b0;
            stg_draw_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mix_reg       <= mix_next;
            weyl_reg      <= weyl_next;
            ring_reg      <= ring_next;
            stg_valid_reg <= stg_valid_next;
            stg_draw_reg  <= stg_draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_addr_reg  <= stg_addr_next;
        stg_wmix_reg  <= stg_wmix_next;
        out_value_reg <= out_value_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.random_value = out_value_reg;

    `XG4K_ASSERT_SAME(a_seed_stage_empty, seed_fire, !stg_valid_reg, "reseed accepted with a step in flight")
    `XG4K_ASSERT_SAME(a_fill_no_step, state_reg == ST_FILL, !stg_valid_reg, "table fill overlaps a step write-back")
    `XG4K_ASSERT_NEXT(a_discard_ring, state_reg == ST_DISCARD && state_next == ST_IDLE, ring_reg == '1, "ring index not at last entry after discard")

endmodule

### hw/rtl/xg4k_table.sv
module xg4k_table #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_cur_addr,
    input  logic [ADDR_W-1:0] rd_lag_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  xg4k_pkg::word_t   wr_data,
    output xg4k_pkg::word_t   step_word
);
    import xg4k_pkg::*;

    word_t mem [DEPTH];
    word_t cur_q_reg;
    word_t lag_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read so a stalled step keeps its operands.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_q_reg <= mem[rd_cur_addr];
            lag_q_reg <= mem[rd_lag_addr];
        end
    end

    assign step_word = step_mix(cur_q_reg, lag_q_reg);

endmodule
